### design/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

  // Eight-way symmetry: one octant point gives eight mirrored pixels.
  localparam int MirrorCount = 8;
  localparam int PhaseBits   = $clog2(MirrorCount);

  typedef logic [PhaseBits-1:0] phase_t;

  localparam phase_t LastPhase = phase_t'(MirrorCount - 1);

  // Input word kinds, carried on in_tuser.
  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  // How one mirrored pixel is formed from the octant offsets.
  // swap: x offset taken from y and y offset from x; neg_*: negate that offset.
  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } mirror_t;

  // Flags that travel with a queued point.
  typedef struct packed {
    logic valid;  // the job carries a point (otherwise nothing was left)
    logic done;   // no point remains after this one
  } job_flags_t;

  // Output order: (+x,+y) (+x,-y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (+y,-x) (-y,-x).
  function automatic mirror_t mirror_of(phase_t ph);
    mirror_t m;
    unique case (ph)
      3'd0: m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      3'd1: m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
      3'd2: m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      3'd3: m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      3'd4: m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      3'd5: m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      3'd6: m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
      3'd7: m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### design/mcr_front.sv
`default_nettype none

module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 9,
  localparam int OffBits    = RADIUS_BITS + 1,
  localparam int DecBits    = RADIUS_BITS + 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Incoming words
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   in_func,
  input  wire logic [COORD_BITS-1:0]  in_cx,
  input  wire logic [COORD_BITS-1:0]  in_cy,
  input  wire logic [RADIUS_BITS-1:0] in_radius,
  // Point jobs toward the queue
  output      logic                   job_valid,
  input  wire logic                   job_ready,
  output      logic [OffBits-1:0]     job_x,
  output      logic [OffBits-1:0]     job_y,
  output      logic [COORD_BITS-1:0]  job_cx,
  output      logic [COORD_BITS-1:0]  job_cy,
  output      job_flags_t             job_flags
);

  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [OffBits-1:0]    ox_r, ox_nxt;
  logic [OffBits-1:0]    oy_r, oy_nxt;
  logic [DecBits-1:0]    dec_r, dec_nxt;

  logic               accept;
  logic               is_advance;
  logic               has_point;
  logic [DecBits-1:0] twice_x;
  logic [DecBits-1:0] twice_y;
  logic [DecBits-1:0] dec_step;
  logic [OffBits-1:0] ox_step;
  logic [OffBits-1:0] oy_step;

  // Every word waits for queue room, so a start never overtakes queued points.
  assign in_ready   = job_ready;
  assign accept     = in_valid && in_ready;
  assign is_advance = (func_t'(in_func) == FUNC_ADVANCE);
  assign has_point  = (ox_r < oy_r);

  // Midpoint decision update from the offsets before the step.
  assign twice_x = DecBits'(ox_r) << 1;
  assign twice_y = DecBits'(oy_r) << 1;
  always_comb begin
    if (dec_r[DecBits-1]) begin
      dec_step = dec_r + twice_x + DecBits'(3);
      oy_step  = oy_r;
    end else begin
      dec_step = dec_r + twice_x - twice_y + DecBits'(5);
      oy_step  = oy_r - OffBits'(1);
    end
  end
  assign ox_step = ox_r + OffBits'(1);

  // A job goes out for every advance word, with or without a point.
  assign job_valid       = accept && is_advance;
  assign job_x           = ox_r;
  assign job_y           = oy_r;
  assign job_cx          = cx_r;
  assign job_cy          = cy_r;
  assign job_flags.valid = has_point;
  assign job_flags.done  = has_point ? !(ox_step < oy_step) : 1'b1;

  // Circle state next value.
  always_comb begin
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    ox_nxt  = ox_r;
    oy_nxt  = oy_r;
    dec_nxt = dec_r;
    if (accept) begin
      if (!is_advance) begin
        cx_nxt  = in_cx;
        cy_nxt  = in_cy;
        ox_nxt  = '0;
        oy_nxt  = OffBits'(in_radius);
        dec_nxt = DecBits'(1) - DecBits'(in_radius);
      end else if (has_point) begin
        ox_nxt  = ox_step;
        oy_nxt  = oy_step;
        dec_nxt = dec_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      ox_r  <= '0;
      oy_r  <= '0;
      dec_r <= '0;
    end else begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      dec_r <= dec_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mcr_queue.sv
`default_nettype none

module mcr_queue #(
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      logic [WIDTH-1:0] pop_data
);

  // Two-entry queue between the front and the back end.
  logic [WIDTH-1:0] slots_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/mcr_back.sv
`default_nettype none

module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 9,
  localparam int OffBits    = RADIUS_BITS + 1,
  localparam int PixBits    = COORD_BITS + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Point jobs from the queue
  input  wire logic                  job_valid,
  output      logic                  job_ready,
  input  wire logic [OffBits-1:0]    job_x,
  input  wire logic [OffBits-1:0]    job_y,
  input  wire logic [COORD_BITS-1:0] job_cx,
  input  wire logic [COORD_BITS-1:0] job_cy,
  input  wire job_flags_t            job_flags,
  // Pixel words
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [PixBits-1:0]    out_px,
  output      logic [PixBits-1:0]    out_py,
  output      logic                  out_pixel_valid,
  output      logic                  out_done,
  output      logic                  out_last
);

  // Current job.
  logic                  active_r, active_nxt;
  phase_t                phase_r, phase_nxt;
  logic [OffBits-1:0]    x_r;
  logic [OffBits-1:0]    y_r;
  logic [COORD_BITS-1:0] cx_r;
  logic [COORD_BITS-1:0] cy_r;
  job_flags_t            flags_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [PixBits-1:0] px_r;
  logic [PixBits-1:0] py_r;
  logic               pv_r;
  logic               done_r;
  logic               last_r;

  logic               emit;
  logic               last_emit;
  logic               load;
  mirror_t            mir;
  logic [OffBits-1:0] mag_x;
  logic [OffBits-1:0] mag_y;
  logic [PixBits-1:0] off_x;
  logic [PixBits-1:0] off_y;
  logic [PixBits-1:0] pix_x;
  logic [PixBits-1:0] pix_y;
  logic               pix_last;

  // A word is produced whenever the output register is free or being drained.
  assign emit      = active_r && (!out_valid_r || out_ready);
  assign pix_last  = !flags_r.valid || (phase_r == LastPhase);
  assign last_emit = emit && pix_last;
  assign load      = job_valid && (!active_r || last_emit);
  assign job_ready = !active_r || last_emit;

  // Mirror selection and offset from the centre, all modulo the pixel width.
  assign mir   = mirror_of(phase_r);
  assign mag_x = mir.swap ? y_r : x_r;
  assign mag_y = mir.swap ? x_r : y_r;
  assign off_x = mir.neg_x ? -PixBits'(mag_x) : PixBits'(mag_x);
  assign off_y = mir.neg_y ? -PixBits'(mag_y) : PixBits'(mag_y);
  assign pix_x = {cx_r[COORD_BITS-1], cx_r} + off_x;
  assign pix_y = {cy_r[COORD_BITS-1], cy_r} + off_y;

  // Job sequencing.
  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    if (load) begin
      active_nxt = 1'b1;
      phase_nxt  = '0;
    end else if (last_emit) begin
      active_nxt = 1'b0;
      phase_nxt  = '0;
    end else if (emit) begin
      phase_nxt = phase_r + phase_t'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job payload capture.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r     <= job_x;
      y_r     <= job_y;
      cx_r    <= job_cx;
      cy_r    <= job_cy;
      flags_r <= job_flags;
    end
  end

  // Output payload; an empty job reports a single word with no pixel.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (flags_r.valid) begin
        px_r   <= pix_x;
        py_r   <= pix_y;
        pv_r   <= 1'b1;
        last_r <= pix_last;
        done_r <= pix_last && flags_r.done;
      end else begin
        px_r   <= '0;
        py_r   <= '0;
        pv_r   <= 1'b0;
        last_r <= 1'b1;
        done_r <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_px          = px_r;
  assign out_py          = py_r;
  assign out_pixel_valid = pv_r;
  assign out_done        = done_r;
  assign out_last        = last_r;

  // A mid-job phase only exists while a job is active.
  a_phase_active : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != '0) |-> active_r)
    else $error("mcr_back: nonzero phase with no active job");

  // A word without a pixel closes its run and the circle.
  a_empty_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pv_r) |-> (last_r && done_r))
    else $error("mcr_back: empty word without last and done");

  // Circle completion is only flagged on the last word of a run.
  a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("mcr_back: done flagged before the last word");

  // A loaded job starts at the first mirror.
  a_load_start : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (active_r && (phase_r == '0)))
    else $error("mcr_back: job load did not restart the phase");

endmodule

`default_nettype wire

### design/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer with eight-way symmetry. A start word (in_tuser = 0) loads the
// center and radius and produces no output; each advance word (in_tuser = 1) produces the eight
// mirrored pixels of the next octant point, one output word per cycle unless out_tready is low,
// with out_tlast on the eighth and circle_done on the eighth of the final point. An advance after
// the last point produces one word with pixel_valid = 0, tlast and circle_done set, and zero
// coordinates. The front end takes one word per cycle while its two-entry point queue has room;
// the back end's single output register emits one pixel per cycle unless out_tready stalls it.
// With the pipeline empty, the first pixel word of an advance passes from the point queue through
// the back end's job registers to its output register after the advance word is accepted.

`default_nettype none

module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 9,
  localparam int OffBits     = RADIUS_BITS + 1,
  localparam int PixBits     = COORD_BITS + 1,
  localparam int InDataBits  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  localparam int OutDataBits = ((2 * PixBits + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [InDataBits-1:0]  in_tdata,   // center_x, center_y, radius, zero fill
  input  wire logic                   in_tuser,   // func
  // Output stream
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OutDataBits-1:0] out_tdata,  // pixel_x, pixel_y, zero fill
  output      logic [1:0]             out_tuser,  // pixel_valid, circle_done
  output      logic                   out_tlast   // last_of_run
);

  localparam int JobBits = 2 * OffBits + 2 * COORD_BITS + $bits(job_flags_t);

  logic                  push_valid;
  logic                  push_ready;
  logic [OffBits-1:0]    f_x;
  logic [OffBits-1:0]    f_y;
  logic [COORD_BITS-1:0] f_cx;
  logic [COORD_BITS-1:0] f_cy;
  job_flags_t            f_flags;
  logic [JobBits-1:0]    push_data;

  logic                  pop_valid;
  logic                  pop_ready;
  logic [JobBits-1:0]    pop_data;
  logic [OffBits-1:0]    b_x;
  logic [OffBits-1:0]    b_y;
  logic [COORD_BITS-1:0] b_cx;
  logic [COORD_BITS-1:0] b_cy;
  job_flags_t            b_flags;

  logic [PixBits-1:0]    px;
  logic [PixBits-1:0]    py;
  logic                  pix_valid;
  logic                  done;

  // Front end: word intake and circle stepping.
  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_cx     (in_tdata[COORD_BITS-1:0]),
    .in_cy     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_radius (in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_x     (f_x),
    .job_y     (f_y),
    .job_cx    (f_cx),
    .job_cy    (f_cy),
    .job_flags (f_flags)
  );

  assign push_data = {f_flags, f_cy, f_cx, f_y, f_x};

  // Point queue.
  mcr_queue #(
    .WIDTH (JobBits)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {b_flags, b_cy, b_cx, b_y, b_x} = pop_data;

  // Back end: mirrored pixel emission.
  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (pop_valid),
    .job_ready       (pop_ready),
    .job_x           (b_x),
    .job_y           (b_y),
    .job_cx          (b_cx),
    .job_cy          (b_cy),
    .job_flags       (b_flags),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_px          (px),
    .out_py          (py),
    .out_pixel_valid (pix_valid),
    .out_done        (done),
    .out_last        (out_tlast)
  );

  assign out_tdata = OutDataBits'({py, px});
  assign out_tuser = {done, pix_valid};

endmodule

`default_nettype wire

### test/circle_pixel_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the circle rasterizer, keeps its own copy of the
// octant walk, and compares every output word against the oldest predicted one.
module circle_pixel_checker
  import mcr_pkg::*;
#(
  parameter int InDataBits  = 40,
  parameter int OutDataBits = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [InDataBits-1:0]  in_tdata,   // center_x, center_y, radius, zero fill
  input  wire logic                   in_tuser,   // func
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OutDataBits-1:0] out_tdata,  // pixel_x, pixel_y, zero fill
  input  wire logic [1:0]             out_tuser,  // pixel_valid, circle_done
  input  wire logic                   out_tlast,  // last_of_run
  output int                          mismatches,
  output int                          outstanding,
  output int                          pixel_words,
  output int                          empty_advances,
  output int                          finished_circles
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [12:0] px;
    logic [12:0] py;
    logic        valid;
    logic        last;
    logic        done;
  } pixel_word_t;

  pixel_word_t expected_pixels[$];

  // Octant walk state: offsets, decision variable and latched centre.
  logic        [9:0]  off_x;
  logic        [9:0]  off_y;
  logic signed [12:0] decision_q;
  logic signed [11:0] ctr_x;
  logic signed [11:0] ctr_y;
  int                 report_count;

  function automatic pixel_word_t place_pixel(int dx, int dy, logic last, logic done);
    pixel_word_t w;
    w.px    = 13'(int'(ctr_x) + dx);
    w.py    = 13'(int'(ctr_y) + dy);
    w.valid = 1'b1;
    w.last  = last;
    w.done  = done;
    return w;
  endfunction

  // Append one predicted word at the tail of the expectation queue.
  task automatic enqueue_word(pixel_word_t w);
    expected_pixels.insert(expected_pixels.size(), w);
  endtask

  // Advance the walk by one input word and queue the pixels it should produce.
  task automatic predict_circle_word(func_t fn, logic [InDataBits-1:0] data);
    int          x;
    int          y;
    int          d;
    logic        done;
    pixel_word_t w;
    if (fn == FUNC_START) begin
      ctr_x      = data[11:0];
      ctr_y      = data[23:12];
      off_x      = '0;
      off_y      = 10'(data[32:24]);
      decision_q = 13'(1 - int'(data[32:24]));
    end else begin
      x = int'(off_x);
      y = int'(off_y);
      d = int'(decision_q);
      if (x >= y) begin
        // Nothing left on this circle: one empty word.
        w       = '0;
        w.last  = 1'b1;
        w.done  = 1'b1;
        enqueue_word(w);
      end else begin
        if (d < 0) begin
          d = d + 2 * x + 3;
        end else begin
          d     = d + 2 * x - 2 * y + 5;
          off_y = 10'(y - 1);
        end
        off_x      = 10'(x + 1);
        decision_q = 13'(d);
        done       = (off_x >= off_y);
        enqueue_word(place_pixel(x, y, 1'b0, 1'b0));
        enqueue_word(place_pixel(x, -y, 1'b0, 1'b0));
        enqueue_word(place_pixel(y, x, 1'b0, 1'b0));
        enqueue_word(place_pixel(-y, x, 1'b0, 1'b0));
        enqueue_word(place_pixel(-x, y, 1'b0, 1'b0));
        enqueue_word(place_pixel(-x, -y, 1'b0, 1'b0));
        enqueue_word(place_pixel(y, -x, 1'b0, 1'b0));
        enqueue_word(place_pixel(-y, -x, 1'b1, done));
      end
    end
  endtask

  task automatic report_word(string what, pixel_word_t want, pixel_word_t got);
    report_count++;
    if (report_count <= ReportLimit) begin
      $display("%0t: %s: expected x=%0d y=%0d valid=%0b last=%0b done=%0b", $realtime, what,
               $signed(want.px), $signed(want.py), want.valid, want.last, want.done);
      $display("%0t: %s:   actual x=%0d y=%0d valid=%0b last=%0b done=%0b", $realtime, what,
               $signed(got.px), $signed(got.py), got.valid, got.last, got.done);
    end
  endtask

  // Output words are checked before the input word of the same edge is predicted.
  always @(posedge clk) begin
    pixel_word_t got;
    pixel_word_t want;
    if (!rst_n) begin
      off_x            = '0;
      off_y            = '0;
      decision_q       = '0;
      ctr_x            = '0;
      ctr_y            = '0;
      report_count     = 0;
      expected_pixels.delete();
      mismatches       <= 0;
      pixel_words      <= 0;
      empty_advances   <= 0;
      finished_circles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[12:0], out_tdata[25:13], out_tuser[0], out_tlast, out_tuser[1]};
        if (got.valid) begin
          pixel_words <= pixel_words + 1;
        end else begin
          empty_advances <= empty_advances + 1;
        end
        if (got.valid && got.done) begin
          finished_circles <= finished_circles + 1;
        end
        if (expected_pixels.size() == 0) begin
          report_word("unexpected word", '0, got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            report_word("word mismatch", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_circle_word(func_t'(in_tuser), in_tdata);
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mcr_pkg::*;

  localparam int InDataBits  = 40;
  localparam int OutDataBits = 32;
  localparam int RandomWords = 280;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [InDataBits-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tready = 1'b0;
  wire logic              in_tready;
  wire logic              out_tvalid;
  wire logic [OutDataBits-1:0] out_tdata;
  wire logic [1:0]        out_tuser;
  wire logic              out_tlast;

  int  idle_pct  = 0;
  int  stall_pct = 0;
  int  words_sent;
  int  starts_sent;
  int  rand_base;
  bit  in_random;
  int  mismatches;
  int  outstanding;
  int  pixel_words;
  int  empty_advances;
  int  finished_circles;

  midpoint_circle_rasterizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  circle_pixel_checker #(
    .InDataBits  (InDataBits),
    .OutDataBits (OutDataBits)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .pixel_words      (pixel_words),
    .empty_advances   (empty_advances),
    .finished_circles (finished_circles)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Drive one word from a falling edge and hold it until the block takes it.
  task automatic send_word(func_t fn, logic [11:0] cx, logic [11:0] cy, logic [8:0] r);
    if (in_random) begin
      case ((words_sent - rand_base) * 4 / RandomWords)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
    end
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = fn;
    in_tdata  = {7'b0, r, cy, cx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (fn == FUNC_START) begin
      starts_sent++;
    end
    @(negedge clk);
  endtask

  // Advances carry random content in the unused fields.
  task automatic send_advance();
    send_word(FUNC_ADVANCE, 12'($urandom), 12'($urandom), 9'($urandom));
  endtask

  initial begin
    logic [8:0] r;
    int         n_adv;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: advance before any start, unit and zero radius at opposite corners,
    // full radius at the extremes, and one circle walked to the end.
    send_advance();
    send_word(FUNC_START, 12'h800, 12'h7ff, 9'd1);
    send_advance();
    send_advance();
    send_word(FUNC_START, 12'h7ff, 12'h800, 9'd0);
    send_advance();
    send_word(FUNC_START, 12'h800, 12'h800, 9'd511);
    repeat (3) send_advance();
    send_word(FUNC_START, 12'h7ff, 12'h7ff, 9'd511);
    repeat (2) send_advance();
    send_word(FUNC_START, 12'hfff, 12'h000, 9'd6);
    repeat (6) send_advance();
    send_word(FUNC_START, 12'h555, 12'haaa, 9'd256);
    send_advance();

    // Random: mostly small circles walked to the end or cut short, some noise.
    in_random = 1'b1;
    rand_base = words_sent;
    while (words_sent - rand_base < RandomWords) begin
      if ($urandom_range(99) < 80) begin
        r = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(24));
        send_word(FUNC_START, 12'($urandom), 12'($urandom), r);
        if (r > 24) begin
          n_adv = $urandom_range(12, 1);
        end else if ($urandom_range(3) == 0) begin
          n_adv = $urandom_range(int'(r) / 2 + 1, 1);
        end else begin
          n_adv = int'(r) * 3 / 4 + 2;
        end
        for (int k = 0; k < n_adv && words_sent - rand_base < RandomWords; k++) begin
          send_advance();
        end
      end else begin
        send_word(func_t'($urandom_range(1)), 12'($urandom), 12'($urandom), 9'($urandom));
      end
    end
    in_tvalid = 1'b0;

    // Drain, then keep watching so that any extra word from the back end shows up.
    while (outstanding != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Sent %0d input words including %0d circle starts.", words_sent, starts_sent);
    $display("Received %0d pixels, %0d empty advances, %0d completed circles, %0d mismatches.",
             pixel_words, empty_advances, finished_circles, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
